// File: sv/bffs_pkg.sv
// ----------------------------------------------------------------------------
// bffs_pkg
// Shared constants, types and the per-field number decoding step for the
// brace frame field scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package bffs_pkg;

  localparam logic [7:0] CH_OPEN   = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE  = 8'h7D;  // '}'
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_FOUR   = 8'h34;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NO_N = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_NEG  = 2'd3;

  // numeric fields in scan order
  localparam int NUM_FIELDS = 6;
  localparam int F_N  = 0;
  localparam int F_D1 = 1;
  localparam int F_D2 = 2;
  localparam int F_D3 = 3;
  localparam int F_D4 = 4;
  localparam int F_T  = 5;

  typedef enum logic [2:0] {
    NP_SEEK,
    NP_SEP,
    NP_WS,
    NP_DIG,
    NP_DONE
  } num_phase_t;

  typedef struct packed {
    num_phase_t  phase;
    logic        neg;
    logic        dig;
    logic [3:0]  digit;
  } num_step_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // one byte through a value decoder that has already seen its name
  function automatic num_step_t num_step(input num_phase_t ph, input logic [7:0] b);
    num_step_t r;
    logic      ws;
    r.phase = ph;
    r.neg   = 1'b0;
    r.dig   = 1'b0;
    r.digit = 4'(b - CH_ZERO);
    ws      = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    case (ph)
      NP_SEP, NP_WS: begin
        if (ph == NP_SEP && (b == CH_COLON || b == CH_SPACE)) begin
          r.phase = NP_SEP;
        end else if (ws) begin
          r.phase = NP_WS;
        end else if (b == CH_MINUS || b == CH_PLUS) begin
          r.phase = NP_DIG;
          r.neg   = (b == CH_MINUS);
        end else if (is_digit(b)) begin
          r.phase = NP_DIG;
          r.dig   = 1'b1;
        end else begin
          r.phase = NP_DONE;
        end
      end
      NP_DIG: begin
        if (is_digit(b)) begin
          r.dig = 1'b1;
        end else begin
          r.phase = NP_DONE;
        end
      end
      default: r.phase = ph;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/brace_frame_field_scanner.sv
// ----------------------------------------------------------------------------
// brace_frame_field_scanner
// Collects a brace framed byte stream into a buffer memory and, on the
// closing brace, scans it for quoted fields N, H, D1..D4 and T.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one byte per item. Bytes
//   outside a frame are ignored; '{' opens or restarts a frame, CR or LF
//   drops it. While collecting, each byte that stays in the frame is taken and
//   written to the frame memory.
//   On '}' the block stops taking items and reads the frame back from the
//   memory, one byte per cycle, feeding six number decoders and a string
//   decoder in parallel. The memory read is registered; after the last byte
//   of the frame is scanned, the result is loaded into the output register
//   as soon as that register is free, and out_valid rises.
//   A byte that finds the buffer full emits a status 2 result at once; it is
//   held off while an earlier result still waits in the output register.
//   The output register lets collection of the next frame go on while the
//   receiver stalls; a finished scan waits in place until it is free.
//   Reset (rst, synchronous) returns to idle with no result pending. The
//   frame memory needs no clearing: only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module brace_frame_field_scanner #(
  parameter int BUFFER_LEN = 64,
  parameter int H_CHARS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      cmd_number,
  output logic [63:0]      h_text,
  output logic [3:0]       h_length,
  output logic [15:0]      d1_value,
  output logic [15:0]      d2_value,
  output logic [15:0]      d3_value,
  output logic [15:0]      d4_value,
  output logic [31:0]      t_value
);
  import bffs_pkg::*;

  localparam int AW = (BUFFER_LEN > 1) ? $clog2(BUFFER_LEN) : 1;
  localparam int CW = $clog2(BUFFER_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_LEN);
  localparam logic [3:0]    HMAX = 4'(H_CHARS);

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_SCAN, S_EMIT} state_t;
  typedef enum logic [1:0] {HP_SEEK, HP_SEP, HP_COPY, HP_DONE} h_phase_t;

  state_t           state;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    rd_addr;
  logic             rd_pend;
  logic             rd_last;
  logic [7:0]       rd_data;
  logic [7:0]       p1, p2, p3;

  logic [7:0]       mem [BUFFER_LEN];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;

  num_phase_t       nphase [NUM_FIELDS];
  logic             nneg   [NUM_FIELDS];
  logic [31:0]      nacc   [NUM_FIELDS];
  logic [NUM_FIELDS-1:0] hit;
  num_step_t        nstep  [NUM_FIELDS];

  h_phase_t         hphase;
  logic [3:0]       hcnt;
  logic [63:0]      htext;
  logic             h_hit;

  logic             accept;
  logic             is_nl;
  logic             overflow;

  logic [31:0]      val [NUM_FIELDS];

  assign is_nl    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign overflow = (state == S_FILL) && !is_nl && (rx_byte != CH_OPEN) && (fill == FULL);
  assign in_ready = (state == S_IDLE) || ((state == S_FILL) && !(overflow && out_valid));
  assign accept   = in_valid && in_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    if (accept && rx_byte == CH_OPEN && (state == S_IDLE || state == S_FILL)) begin
      mem_we = 1'b1;
    end else if (accept && state == S_FILL && !is_nl && !overflow) begin
      mem_we = 1'b1;
      mem_wa = fill[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= rx_byte;
    end
    rd_data <= mem[rd_addr[AW-1:0]];
  end

  // name matches end on the closing quote of the current byte
  always_comb begin
    hit[F_N]  = (p2 == CH_QUOTE) && (p1 == CH_N) && (rd_data == CH_QUOTE);
    hit[F_T]  = (p2 == CH_QUOTE) && (p1 == CH_T) && (rd_data == CH_QUOTE);
    hit[F_D1] = (p3 == CH_QUOTE) && (p2 == CH_D) && (p1 == CH_ONE) && (rd_data == CH_QUOTE);
    hit[F_D2] = (p3 == CH_QUOTE) && (p2 == CH_D) && (p1 == CH_TWO) && (rd_data == CH_QUOTE);
    hit[F_D3] = (p3 == CH_QUOTE) && (p2 == CH_D) && (p1 == CH_THREE) && (rd_data == CH_QUOTE);
    hit[F_D4] = (p3 == CH_QUOTE) && (p2 == CH_D) && (p1 == CH_FOUR) && (rd_data == CH_QUOTE);
    h_hit     = (p2 == CH_QUOTE) && (p1 == CH_H) && (rd_data == CH_QUOTE);
    for (int i = 0; i < NUM_FIELDS; i++) begin
      nstep[i] = num_step(nphase[i], rd_data);
      val[i]   = nneg[i] ? (32'd0 - nacc[i]) : nacc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_addr   <= '0;
      rd_pend   <= 1'b0;
      rd_last   <= 1'b0;
      out_valid <= 1'b0;
      hphase    <= HP_SEEK;
      hcnt      <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        nphase[i] <= NP_SEEK;
      end
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && rx_byte == CH_OPEN) begin
            fill  <= CW'(1);
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (accept) begin
            if (is_nl) begin
              fill  <= '0;
              state <= S_IDLE;
            end else if (rx_byte == CH_OPEN) begin
              fill <= CW'(1);
            end else if (overflow) begin
              // drop the frame, report it
              fill       <= '0;
              state      <= S_IDLE;
              out_valid  <= 1'b1;
              status     <= ST_LONG;
              cmd_number <= 16'hFFFF;
              h_text     <= '0;
              h_length   <= '0;
              d1_value   <= '0;
              d2_value   <= '0;
              d3_value   <= '0;
              d4_value   <= '0;
              t_value    <= '0;
            end else begin
              fill <= fill + CW'(1);
              if (rx_byte == CH_CLOSE) begin
                state   <= S_SCAN;
                rd_addr <= '0;
                rd_pend <= 1'b0;
                p1      <= '0;
                p2      <= '0;
                p3      <= '0;
                hphase  <= HP_SEEK;
                hcnt    <= '0;
                htext   <= '0;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                  nphase[i] <= NP_SEEK;
                  nneg[i]   <= 1'b0;
                  nacc[i]   <= '0;
                end
              end
            end
          end
        end
        S_SCAN: begin
          // read issue stops at fill, which also drops rd_pend after the last byte
          if (rd_addr < fill) begin
            rd_pend <= 1'b1;
            rd_last <= (rd_addr == fill - CW'(1));
            rd_addr <= rd_addr + CW'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            p1 <= rd_data;
            p2 <= p1;
            p3 <= p2;
            for (int i = 0; i < NUM_FIELDS; i++) begin
              if (nphase[i] == NP_SEEK) begin
                if (hit[i]) begin
                  nphase[i] <= NP_SEP;
                end
              end else begin
                nphase[i] <= nstep[i].phase;
                if (nstep[i].neg) begin
                  nneg[i] <= 1'b1;
                end
                if (nstep[i].dig) begin
                  nacc[i] <= (nacc[i] << 3) + (nacc[i] << 1) + 32'(nstep[i].digit);
                end
              end
            end
            case (hphase)
              HP_SEEK: if (h_hit) hphase <= HP_SEP;
              HP_SEP: begin
                if (rd_data == CH_QUOTE) begin
                  hphase <= HP_COPY;
                end else if (rd_data != CH_COLON && rd_data != CH_SPACE) begin
                  hphase <= HP_DONE;
                end
              end
              HP_COPY: begin
                if (rd_data == CH_QUOTE || hcnt == HMAX) begin
                  hphase <= HP_DONE;
                end else begin
                  htext[8*hcnt[2:0] +: 8] <= rd_data;
                  hcnt <= hcnt + 4'd1;
                end
              end
              default: hphase <= hphase;
            endcase
            if (rd_last) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            fill      <= '0;
            state     <= S_IDLE;
            if (nphase[F_N] == NP_SEEK) begin
              status     <= ST_NO_N;
              cmd_number <= 16'hFFFF;
              h_text     <= '0;
              h_length   <= '0;
              d1_value   <= '0;
              d2_value   <= '0;
              d3_value   <= '0;
              d4_value   <= '0;
              t_value    <= '0;
            end else begin
              status     <= val[F_N][15] ? ST_NEG : ST_OK;
              cmd_number <= val[F_N][15:0];
              h_text     <= htext;
              h_length   <= hcnt;
              d1_value   <= val[F_D1][15:0];
              d2_value   <= val[F_D2][15:0];
              d3_value   <= val[F_D3][15:0];
              d4_value   <= val[F_D4][15:0];
              t_value    <= val[F_T];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_input_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_EMIT) |-> !in_ready)
    else $error("input taken during scan");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond buffer");
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_SCAN)
    else $error("read data outside scan");
  a_h_bound: assert property (@(posedge clk) disable iff (rst)
    hcnt <= HMAX)
    else $error("H length beyond limit");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_valid) |=> out_valid && state == S_IDLE)
    else $error("finished scan not delivered");
`endif

endmodule

`default_nettype wire
